>>> design/fraexe_pkg.sv
`timescale 1ns / 1ps

package fraexe_pkg;

   localparam int NUM_REGS     = 4;
   localparam int DATA_WIDTH   = 32;
   localparam int PC_WIDTH     = 16;
   localparam int REG_IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int DIV_CNT_W    = $clog2(DATA_WIDTH);
   localparam int FIELD_WIDTH  = 32;
   localparam int PC_OUT_WIDTH = 16;

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef enum logic [2:0] {
      OP_MOV,
      OP_ADD,
      OP_MUL,
      OP_DIV,
      OP_INC,
      OP_DEC,
      OP_END,
      OP_UNKNOWN
   } opcode_type;

   typedef enum logic [1:0] {
      SRC_REG,
      SRC_IMM,
      SRC_INVALID
   } source_kind_type;

   typedef enum logic [3:0] {
      ST_OK,
      ST_UNKNOWN,
      ST_MISSING,
      ST_BAD_DEST,
      ST_TOO_MANY,
      ST_NEEDS_TWO,
      ST_BAD_SRC,
      ST_DIV_ZERO,
      ST_END,
      ST_END_ARGS,
      ST_HALTED
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_EXEC,
      S_DIVIDE,
      S_DIV_FIX,
      S_EMIT
   } state_type;

   typedef struct packed {
      opcode_type               operation;
      logic [1:0]               operand_count;
      logic                     dest_is_register;
      logic [1:0]               dest_index;
      logic [1:0]               source_kind;
      logic [1:0]               source_index;
      logic signed [FIELD_WIDTH-1:0] immediate;
   } req_payload_type;

   typedef struct packed {
      status_type                    status;
      logic [PC_OUT_WIDTH-1:0]       program_counter;
      logic signed [FIELD_WIDTH-1:0] reg_a;
      logic signed [FIELD_WIDTH-1:0] reg_b;
      logic signed [FIELD_WIDTH-1:0] reg_c;
      logic signed [FIELD_WIDTH-1:0] reg_d;
   } rsp_payload_type;

   typedef struct packed {
      logic load_item;
      logic fetch_src;
      logic execute;
      logic div_step;
      logic div_finish;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic div_go;
      logic div_last;
      logic out_free;
   } dp_stat_type;

endpackage

>>> design/fraexe_req_if.sv
`timescale 1ns / 1ps

interface fraexe_req_if;
   import fraexe_pkg::*;

   logic                          valid;
   logic                          ready;
   opcode_type                    operation;
   logic [1:0]                    operand_count;
   logic                          dest_is_register;
   logic [1:0]                    dest_index;
   logic [1:0]                    source_kind;
   logic [1:0]                    source_index;
   logic signed [FIELD_WIDTH-1:0] immediate;

   modport source (
      output valid, operation, operand_count, dest_is_register, dest_index,
             source_kind, source_index, immediate,
      input  ready
   );

   modport sink (
      input  valid, operation, operand_count, dest_is_register, dest_index,
             source_kind, source_index, immediate,
      output ready
   );

endinterface

>>> design/fraexe_rsp_if.sv
`timescale 1ns / 1ps

interface fraexe_rsp_if;
   import fraexe_pkg::*;

   logic                          valid;
   logic                          ready;
   status_type                    status;
   logic [PC_OUT_WIDTH-1:0]       program_counter;
   logic signed [FIELD_WIDTH-1:0] reg_a;
   logic signed [FIELD_WIDTH-1:0] reg_b;
   logic signed [FIELD_WIDTH-1:0] reg_c;
   logic signed [FIELD_WIDTH-1:0] reg_d;

   modport source (
      output valid, status, program_counter, reg_a, reg_b, reg_c, reg_d,
      input  ready
   );

   modport sink (
      input  valid, status, program_counter, reg_a, reg_b, reg_c, reg_d,
      output ready
   );

endinterface

>>> design/four_register_alu_executor_unit.sv
`timescale 1ns / 1ps
// Executes one pre-decoded instruction per transfer on four signed registers.
// The request channel carries the opcode, operand count, destination and
// source descriptors and an immediate; the response channel returns a status
// code, the instruction counter before this instruction and all four
// registers after it. Each request yields exactly one response.
// Every instruction passes through fetch, execute and result-load cycles.
// A legal DIV adds a divide phase after execute: the divider resolves one
// quotient bit per cycle, then applies the sign in a separate state.
// The response is held in an output register, so a new request is taken while
// an earlier response still waits. If the receiver stalls longer than one
// instruction, the next instruction waits before its result load and no
// further requests are taken until the output register drains.
// After END the block is halted: later requests return the halted status and
// change nothing. Synchronous reset clears all registers, the counter, the
// halted flag and the response valid.

module four_register_alu_executor_unit (
   input  logic         clock,
   input  logic         reset,
   fraexe_req_if.sink   req_channel,
   fraexe_rsp_if.source rsp_channel
);
   import fraexe_pkg::*;

   dp_cmd_type      cmd;
   dp_stat_type     stat;
   req_payload_type req_data;
   rsp_payload_type rsp_data;
   logic            req_ready;
   logic            rsp_valid;

   assign req_data.operation        = req_channel.operation;
   assign req_data.operand_count    = req_channel.operand_count;
   assign req_data.dest_is_register = req_channel.dest_is_register;
   assign req_data.dest_index       = req_channel.dest_index;
   assign req_data.source_kind      = req_channel.source_kind;
   assign req_data.source_index     = req_channel.source_index;
   assign req_data.immediate        = req_channel.immediate;

   fraexe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fraexe_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_channel.ready),
      .rsp_data  (rsp_data)
   );

   assign req_channel.ready           = req_ready;
   assign rsp_channel.valid           = rsp_valid;
   assign rsp_channel.status          = rsp_data.status;
   assign rsp_channel.program_counter = rsp_data.program_counter;
   assign rsp_channel.reg_a           = rsp_data.reg_a;
   assign rsp_channel.reg_b           = rsp_data.reg_b;
   assign rsp_channel.reg_c           = rsp_data.reg_c;
   assign rsp_channel.reg_d           = rsp_data.reg_d;

endmodule

>>> design/fraexe_ctrl.sv
`timescale 1ns / 1ps

module fraexe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  fraexe_pkg::dp_stat_type  stat,
   output fraexe_pkg::dp_cmd_type   cmd
);
   import fraexe_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = stat.div_go ? S_DIVIDE : S_EMIT;
         end
         S_DIVIDE: begin
            if (stat.div_last) begin
               state_in = S_DIV_FIX;
            end
         end
         S_DIV_FIX: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         S_FETCH: begin
            cmd.fetch_src = 1'b1;
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         S_DIV_FIX: begin
            cmd.div_finish = 1'b1;
         end
         S_EMIT: begin
            cmd.load_out = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

>>> design/fraexe_dpath.sv
`timescale 1ns / 1ps

module fraexe_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  fraexe_pkg::dp_cmd_type      cmd,
   output fraexe_pkg::dp_stat_type     stat,
   input  fraexe_pkg::req_payload_type req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output fraexe_pkg::rsp_payload_type rsp_data
);
   import fraexe_pkg::*;

   word_type              regs_ff [NUM_REGS];
   word_type              regs_in [NUM_REGS];
   req_payload_type       item_ff;
   logic [PC_WIDTH-1:0]   item_pc_ff;
   logic [PC_WIDTH-1:0]   pc_ff;
   logic [PC_WIDTH-1:0]   pc_in;
   logic                  halted_ff;
   logic                  halted_in;
   word_type              opb_ff;
   status_type            status_ff;
   word_type              div_rem_ff;
   word_type              div_quo_ff;
   word_type              div_den_ff;
   logic                  div_neg_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_data_ff;

   logic [REG_IDX_W-1:0]  rd_idx;
   word_type              rd_data;
   word_type              imm_ext;
   word_type              product;
   word_type              exec_result;
   word_type              quotient;
   logic [DATA_WIDTH:0]   div_trial;
   logic                  two_operands;
   logic                  src_reg_ok;
   logic                  src_ok;
   status_type            exec_status;
   logic                  write_en;
   word_type              write_data;
   logic [FIELD_WIDTH-1:0] out_regs [4];

   assign rd_idx  = cmd.fetch_src ? REG_IDX_W'(item_ff.source_index)
                                  : REG_IDX_W'(item_ff.dest_index);
   assign rd_data = regs_ff[rd_idx];
   assign imm_ext = DATA_WIDTH'($signed(item_ff.immediate));
   assign product = rd_data * opb_ff;

   assign two_operands = !(item_ff.operation == OP_INC || item_ff.operation == OP_DEC);
   assign src_reg_ok   = (item_ff.source_kind == SRC_REG)
                         && (int'(item_ff.source_index) < NUM_REGS);
   assign src_ok       = src_reg_ok || (item_ff.source_kind == SRC_IMM);

   always_comb begin
      if (halted_ff) begin
         exec_status = ST_HALTED;
      end else if (item_ff.operation == OP_UNKNOWN) begin
         exec_status = ST_UNKNOWN;
      end else if (item_ff.operation == OP_END) begin
         exec_status = (item_ff.operand_count != 2'd0) ? ST_END_ARGS : ST_END;
      end else if (item_ff.operand_count == 2'd0) begin
         exec_status = ST_MISSING;
      end else if (!item_ff.dest_is_register || int'(item_ff.dest_index) >= NUM_REGS) begin
         exec_status = ST_BAD_DEST;
      end else if (!two_operands && item_ff.operand_count >= 2'd2) begin
         exec_status = ST_TOO_MANY;
      end else if (two_operands && item_ff.operand_count < 2'd2) begin
         exec_status = ST_NEEDS_TWO;
      end else if (two_operands && !src_ok) begin
         exec_status = ST_BAD_SRC;
      end else if (item_ff.operation == OP_DIV && opb_ff == '0) begin
         exec_status = ST_DIV_ZERO;
      end else begin
         exec_status = ST_OK;
      end
   end

   always_comb begin
      case (item_ff.operation)
         OP_MOV:  exec_result = opb_ff;
         OP_ADD:  exec_result = rd_data + opb_ff;
         OP_MUL:  exec_result = product;
         OP_INC:  exec_result = rd_data + DATA_WIDTH'(1);
         OP_DEC:  exec_result = rd_data - DATA_WIDTH'(1);
         default: exec_result = rd_data;
      endcase
   end

   assign quotient  = div_neg_ff ? (~div_quo_ff + DATA_WIDTH'(1)) : div_quo_ff;
   assign div_trial = {div_rem_ff, div_quo_ff[DATA_WIDTH-1]} - {1'b0, div_den_ff};

   always_comb begin
      write_en   = 1'b0;
      write_data = exec_result;
      if (cmd.execute && exec_status == ST_OK && item_ff.operation != OP_DIV) begin
         write_en = 1'b1;
      end else if (cmd.div_finish) begin
         write_en   = 1'b1;
         write_data = quotient;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         regs_in[i] = regs_ff[i];
         if (write_en && int'(item_ff.dest_index) == i) begin
            regs_in[i] = write_data;
         end
      end
   end

   always_comb begin
      pc_in     = pc_ff;
      halted_in = halted_ff;
      if (cmd.execute && !halted_ff) begin
         if (item_ff.operation == OP_END) begin
            halted_in = 1'b1;
         end else begin
            pc_in = pc_ff + PC_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         regs_ff   <= regs_in;
         pc_ff     <= pc_in;
         halted_ff <= halted_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff    <= req_data;
         item_pc_ff <= pc_ff;
      end
      if (cmd.fetch_src) begin
         opb_ff <= (item_ff.source_kind == SRC_IMM) ? imm_ext : rd_data;
      end
      if (cmd.execute) begin
         status_ff  <= exec_status;
         div_rem_ff <= '0;
         div_quo_ff <= rd_data[DATA_WIDTH-1] ? (~rd_data + DATA_WIDTH'(1)) : rd_data;
         div_den_ff <= opb_ff[DATA_WIDTH-1] ? (~opb_ff + DATA_WIDTH'(1)) : opb_ff;
         div_neg_ff <= rd_data[DATA_WIDTH-1] ^ opb_ff[DATA_WIDTH-1];
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         if (!div_trial[DATA_WIDTH]) begin
            div_rem_ff <= div_trial[DATA_WIDTH-1:0];
            div_quo_ff <= {div_quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            div_rem_ff <= {div_rem_ff[DATA_WIDTH-2:0], div_quo_ff[DATA_WIDTH-1]};
            div_quo_ff <= {div_quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
      end
      if (cmd.load_out) begin
         rsp_data_ff.status          <= status_ff;
         rsp_data_ff.program_counter <= PC_OUT_WIDTH'(item_pc_ff);
         rsp_data_ff.reg_a           <= out_regs[0];
         rsp_data_ff.reg_b           <= out_regs[1];
         rsp_data_ff.reg_c           <= out_regs[2];
         rsp_data_ff.reg_d           <= out_regs[3];
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         out_regs[i] = '0;
         if (i < NUM_REGS) begin
            out_regs[i] = FIELD_WIDTH'($signed(regs_ff[i]));
         end
      end
   end

   assign stat.div_go   = cmd.execute && exec_status == ST_OK && item_ff.operation == OP_DIV;
   assign stat.div_last = (div_cnt_ff == DIV_CNT_W'(DATA_WIDTH - 1));
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> tb/four_register_alu_executor_unit_tb.sv
`timescale 1ns / 1ps

module four_register_alu_executor_unit_tb;
   import fraexe_pkg::*;

   localparam logic [1:0] SRC_UNDEFINED = 2'd3;
   localparam logic [1:0] REG_A = 2'd0;
   localparam logic [1:0] REG_B = 2'd1;
   localparam logic [1:0] REG_C = 2'd2;
   localparam logic [1:0] REG_D = 2'd3;
   localparam logic [31:0] WORD_MIN = 32'h8000_0000;
   localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] MINUS_ONE = 32'hFFFF_FFFF;
   localparam int RANDOM_ITEMS = 1820;
   localparam int PAUSE_AT = 900;
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fraexe_req_if req_ch ();
   fraexe_rsp_if rsp_ch ();

   logic            req_valid = 1'b0;
   req_payload_type req_item  = '0;
   logic            rsp_ready = 1'b0;

   assign req_ch.valid            = req_valid;
   assign req_ch.operation        = req_item.operation;
   assign req_ch.operand_count    = req_item.operand_count;
   assign req_ch.dest_is_register = req_item.dest_is_register;
   assign req_ch.dest_index       = req_item.dest_index;
   assign req_ch.source_kind      = req_item.source_kind;
   assign req_ch.source_index     = req_item.source_index;
   assign req_ch.immediate        = req_item.immediate;
   assign rsp_ch.ready            = rsp_ready;

   four_register_alu_executor_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_ch),
      .rsp_channel (rsp_ch)
   );

   always #5 clock = ~clock;

   // Architectural state tracked alongside the block.
   word_type              gpr [NUM_REGS] = '{default: '0};
   logic [PC_WIDTH-1:0]   exec_pc        = '0;
   logic                  exec_halted    = 1'b0;

   req_payload_type instr_q [$];
   rsp_payload_type expected_q [$];

   int  mismatch_count = 0;
   int  results_seen   = 0;
   int  sent_count     = 0;
   int  send_gap       = 0;
   int  recv_gap       = 0;
   int  gap            = 0;
   int  recv_draw      = 0;
   int  hold_left      = 0;
   logic hold_started  = 1'b0;
   logic send_burst    = 1'b0;
   logic recv_burst    = 1'b0;
   logic launch;
   rsp_payload_type want;

   function automatic rsp_payload_type execute_instruction(input req_payload_type ins);
      rsp_payload_type res;
      logic [1:0]      cnt;
      logic            two;
      logic            advance;
      word_type        val;
      word_type        d;
      word_type        ma;
      word_type        mb;
      word_type        q;
      status_type      st;
      cnt = (ins.operand_count == 2'd3) ? 2'd2 : ins.operand_count;
      two = (ins.operation != OP_INC) && (ins.operation != OP_DEC);
      advance = 1'b1;
      st = ST_OK;
      val = '0;
      d = gpr[ins.dest_index];
      res.program_counter = exec_pc;
      if (exec_halted) begin
         st = ST_HALTED;
         advance = 1'b0;
      end else if (ins.operation == OP_UNKNOWN) begin
         st = ST_UNKNOWN;
      end else if (ins.operation == OP_END) begin
         exec_halted = 1'b1;
         advance = 1'b0;
         st = (cnt != 2'd0) ? ST_END_ARGS : ST_END;
      end else if (cnt == 2'd0) begin
         st = ST_MISSING;
      end else if (!ins.dest_is_register) begin
         st = ST_BAD_DEST;
      end else if (!two && cnt == 2'd2) begin
         st = ST_TOO_MANY;
      end else if (two && cnt == 2'd1) begin
         st = ST_NEEDS_TWO;
      end else if (two && ins.source_kind != SRC_REG && ins.source_kind != SRC_IMM) begin
         st = ST_BAD_SRC;
      end else begin
         if (ins.source_kind == SRC_REG) begin
            val = gpr[ins.source_index];
         end else begin
            val = ins.immediate;
         end
         case (ins.operation)
            OP_MOV: d = val;
            OP_ADD: d = d + val;
            OP_MUL: d = d * val;
            OP_DIV: begin
               if (val == '0) begin
                  st = ST_DIV_ZERO;
               end else begin
                  ma = d[DATA_WIDTH-1] ? -d : d;
                  mb = val[DATA_WIDTH-1] ? -val : val;
                  q = ma / mb;
                  d = (d[DATA_WIDTH-1] ^ val[DATA_WIDTH-1]) ? -q : q;
               end
            end
            OP_INC: d = d + DATA_WIDTH'(1);
            default: d = d - DATA_WIDTH'(1);
         endcase
         if (st == ST_OK) begin
            gpr[ins.dest_index] = d;
         end
      end
      if (advance) begin
         exec_pc = exec_pc + PC_WIDTH'(1);
      end
      res.status = st;
      res.reg_a = gpr[0];
      res.reg_b = gpr[1];
      res.reg_c = gpr[2];
      res.reg_d = gpr[3];
      return res;
   endfunction

   task automatic add_instr(input opcode_type op, input logic [1:0] cnt, input logic dreg,
                            input logic [1:0] didx, input logic [1:0] skind,
                            input logic [1:0] sidx, input logic [31:0] imm);
      req_payload_type ins;
      ins.operation        = op;
      ins.operand_count    = cnt;
      ins.dest_is_register = dreg;
      ins.dest_index       = didx;
      ins.source_kind      = skind;
      ins.source_index     = sidx;
      ins.immediate        = imm;
      instr_q.push_back(ins);
   endtask

   function automatic logic [31:0] operand_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 32'd1;
         2: return MINUS_ONE;
         3: return WORD_MIN;
         4: return WORD_MAX;
         5: return $urandom_range(0, 200) - 100;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_wellformed();
      opcode_type op;
      logic [1:0] cnt;
      op = opcode_type'($urandom_range(0, 5));
      if (op == OP_INC || op == OP_DEC) begin
         cnt = 2'd1;
      end else begin
         cnt = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'd2;
      end
      add_instr(op, cnt, 1'b1, 2'($urandom_range(0, 3)),
                $urandom_range(0, 1) ? SRC_IMM : SRC_REG,
                2'($urandom_range(0, 3)), operand_value());
   endtask

   // END is left out here so that the block keeps executing.
   task automatic add_noise();
      opcode_type op;
      op = opcode_type'($urandom_range(0, 6));
      if (op == OP_END) begin
         op = OP_UNKNOWN;
      end
      add_instr(op, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                2'($urandom_range(0, 3)), $urandom);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      if (mismatch_count < 100) begin
         $display("mismatch at result %0d: %s is %h, expected %h",
                  results_seen, what, got, exp_val);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         launch = 1'b0;
         if (req_valid && req_ch.ready) begin
            expected_q.push_back(execute_instruction(req_item));
            sent_count++;
            if (sent_count % 64 == 0) begin
               send_burst = ($urandom_range(0, 3) == 0);
            end
            gap = send_burst ? 0 : $urandom_range(0, 17);
            if (gap == 0) begin
               launch = 1'b1;
            end else begin
               req_valid <= 1'b0;
               send_gap = gap;
            end
         end else if (!req_valid) begin
            if (send_gap != 0) begin
               send_gap--;
            end else begin
               launch = 1'b1;
            end
         end
         if (launch) begin
            if (instr_q.size() != 0 &&
                !(sent_count == PAUSE_AT && expected_q.size() != 0)) begin
               req_item <= instr_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_ready && rsp_ch.valid) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected transfer, status", 32'(rsp_ch.status), '0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_ch.status !== want.status) begin
                  report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
               end
               if (rsp_ch.program_counter !== want.program_counter) begin
                  report_mismatch("program_counter", 32'(rsp_ch.program_counter),
                                  32'(want.program_counter));
               end
               if (rsp_ch.reg_a !== want.reg_a) begin
                  report_mismatch("reg_a", rsp_ch.reg_a, want.reg_a);
               end
               if (rsp_ch.reg_b !== want.reg_b) begin
                  report_mismatch("reg_b", rsp_ch.reg_b, want.reg_b);
               end
               if (rsp_ch.reg_c !== want.reg_c) begin
                  report_mismatch("reg_c", rsp_ch.reg_c, want.reg_c);
               end
               if (rsp_ch.reg_d !== want.reg_d) begin
                  report_mismatch("reg_d", rsp_ch.reg_d, want.reg_d);
               end
            end
            results_seen <= results_seen + 1;
            if ((results_seen + 1) % 64 == 0) begin
               recv_burst = ($urandom_range(0, 3) == 0);
            end
            recv_draw = recv_burst ? 0 : $urandom_range(0, 17);
            if (recv_draw != 0 || hold_left != 0) begin
               rsp_ready <= 1'b0;
               recv_gap = recv_draw;
            end
         end else if (rsp_ready) begin
            if (hold_left != 0) begin
               rsp_ready <= 1'b0;
            end
         end else if (recv_gap != 0) begin
            recv_gap--;
         end else if (hold_left == 0) begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // The receiver holds off once for a long stretch so that the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_started <= 1'b0;
      end else if (!hold_started && results_seen == HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_started <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   initial begin
      add_instr(OP_MOV, 2'd2, 1'b1, REG_A, SRC_IMM, REG_A, WORD_MAX);
      add_instr(OP_MOV, 2'd2, 1'b1, REG_B, SRC_IMM, REG_D, WORD_MIN);
      add_instr(OP_ADD, 2'd2, 1'b1, REG_A, SRC_IMM, REG_C, 32'd1);
      add_instr(OP_MOV, 2'd2, 1'b1, REG_C, SRC_IMM, REG_B, MINUS_ONE);
      add_instr(OP_DIV, 2'd2, 1'b1, REG_B, SRC_REG, REG_C, '0);
      add_instr(OP_MUL, 2'd2, 1'b1, REG_A, SRC_REG, REG_B, '0);
      add_instr(OP_DIV, 2'd2, 1'b1, REG_A, SRC_IMM, REG_A, '0);
      add_instr(OP_DIV, 2'd2, 1'b1, REG_D, SRC_REG, REG_D, MINUS_ONE);
      add_instr(OP_MOV, 2'd2, 1'b1, REG_D, SRC_IMM, REG_A, 32'd7);
      add_instr(OP_DIV, 2'd2, 1'b1, REG_D, SRC_IMM, REG_A, 32'hFFFF_FFFE);
      add_instr(OP_INC, 2'd1, 1'b1, REG_C, SRC_UNDEFINED, REG_D, $urandom);
      add_instr(OP_DEC, 2'd1, 1'b1, REG_C, SRC_INVALID, REG_B, $urandom);
      add_instr(OP_INC, 2'd2, 1'b1, REG_A, SRC_IMM, REG_A, 32'd5);
      add_instr(OP_DEC, 2'd3, 1'b1, REG_B, SRC_REG, REG_A, 32'd5);
      add_instr(OP_ADD, 2'd1, 1'b1, REG_A, SRC_IMM, REG_A, 32'd5);
      add_instr(OP_MOV, 2'd0, 1'b1, REG_A, SRC_IMM, REG_A, 32'd5);
      add_instr(OP_MOV, 2'd2, 1'b0, REG_D, SRC_IMM, REG_A, 32'd5);
      add_instr(OP_ADD, 2'd2, 1'b1, REG_A, SRC_INVALID, REG_A, 32'd5);
      add_instr(OP_ADD, 2'd2, 1'b1, REG_B, SRC_UNDEFINED, REG_C, 32'd5);
      add_instr(OP_UNKNOWN, 2'd2, 1'b1, REG_A, SRC_IMM, REG_A, WORD_MAX);
      add_instr(OP_MOV, 2'd3, 1'b1, REG_C, SRC_IMM, REG_A, '0);
      add_instr(OP_MUL, 2'd2, 1'b1, REG_D, SRC_IMM, REG_A, WORD_MIN);
      add_instr(OP_MOV, 2'd2, 1'b1, REG_D, SRC_REG, REG_B, '0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 3) != 0) begin
            add_wellformed();
         end else begin
            add_noise();
         end
      end
      add_instr(OP_END, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                2'($urandom_range(0, 3)), $urandom);
      for (int i = 0; i < 4; i++) begin
         add_noise();
      end
      add_instr(OP_END, 2'd2, 1'b1, REG_A, SRC_IMM, REG_A, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (instr_q.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> four_register_alu_executor_unit.f
design/fraexe_pkg.sv
design/fraexe_req_if.sv
design/fraexe_rsp_if.sv
design/fraexe_ctrl.sv
design/fraexe_dpath.sv
design/four_register_alu_executor_unit.sv
tb/four_register_alu_executor_unit_tb.sv
